### rtl/gray4_frame_buffer_engine_assert.svh
// Assertion macros for the gray frame store engine.
`ifndef GRAY4_FRAME_BUFFER_ENGINE_ASSERT_SVH
`define GRAY4_FRAME_BUFFER_ENGINE_ASSERT_SVH
`ifndef ASSERT_OFF
`define GFB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gfb assertion failed");
`define GFB_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("gfb assertion failed");
`else
`define GFB_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define GFB_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

### rtl/gfb_pkg.sv
// Shared constants, types and helpers of the gray frame store engine.
package gfb_pkg;

    localparam int PANEL_WIDTH  = 256;
    localparam int PANEL_HEIGHT = 64;
    localparam int ROW_BYTES    = (PANEL_WIDTH + 1) / 2;
    localparam int STORE_BYTES  = ROW_BYTES * PANEL_HEIGHT;
    localparam int ADDRW        = $clog2(STORE_BYTES);
    localparam int COLW         = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;

    localparam int CMDW   = 2;
    localparam int XW     = 9;
    localparam int YW     = 7;
    localparam int COLORW = 8;
    localparam int BIDXW  = 13;
    localparam int GRAYW  = 4;
    localparam int BYTEW  = 8;

    typedef logic [CMDW-1:0] cmd_t;

    localparam cmd_t CMD_WRITE_PIXEL = 2'd0;
    localparam cmd_t CMD_FILL_RECT   = 2'd1;
    localparam cmd_t CMD_READ_PIXEL  = 2'd2;
    localparam cmd_t CMD_READ_BYTE   = 2'd3;

    localparam logic [BYTEW-1:0] HI_NIB_MASK = 8'hf0;
    localparam logic [BYTEW-1:0] LO_NIB_MASK = 8'h0f;

    // Byte address of a column pair in the store: row times ROW_BYTES plus column.
    function automatic logic [ADDRW-1:0] pix_addr(input logic [YW-1:0] y,
                                                  input logic [COLW-1:0] col);
        return ADDRW'(y) * ADDRW'(ROW_BYTES) + ADDRW'(col);
    endfunction

    // Replace the selected nibbles of a packed byte with the gray level.
    function automatic logic [BYTEW-1:0] put_nibble(input logic [BYTEW-1:0] old,
                                                    input logic hi_en,
                                                    input logic lo_en,
                                                    input logic [GRAYW-1:0] gray);
        logic [BYTEW-1:0] mask;
        mask = (hi_en ? HI_NIB_MASK : '0) | (lo_en ? LO_NIB_MASK : '0);
        return (old & ~mask) | ({gray, gray} & mask);
    endfunction

endpackage

### rtl/gfb_if.sv
// Request and response channel interfaces of the gray frame store engine.
interface gfb_req_if
    import gfb_pkg::*;
();
    logic              valid;
    logic              ready;
    cmd_t              command;
    logic [XW-1:0]     x_start;
    logic [YW-1:0]     y_start;
    logic [XW-1:0]     x_end;
    logic [YW-1:0]     y_end;
    logic [COLORW-1:0] color;
    logic [BIDXW-1:0]  byte_index;

    modport source
    (
        output valid, command, x_start, y_start, x_end, y_end, color, byte_index,
        input  ready
    );
    modport sink
    (
        input  valid, command, x_start, y_start, x_end, y_end, color, byte_index,
        output ready
    );
endinterface

interface gfb_rsp_if
    import gfb_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [GRAYW-1:0] pixel_value;
    logic [BYTEW-1:0] read_byte;
    logic             out_of_range;

    modport source
    (
        output valid, pixel_value, read_byte, out_of_range,
        input  ready
    );
    modport sink
    (
        input  valid, pixel_value, read_byte, out_of_range,
        output ready
    );
endinterface

### rtl/gray4_frame_buffer_engine.sv
// Gray frame store engine: 4-bit pixels packed two per byte, one command word in, one out.
// Pixel write, pixel read, byte read: store read in IDLE, then modify/write-back in EXEC.
// Fill: per row byte, FILL writes both nibbles or reads an edge byte that FILL_WR merges.
// Output register holds a result while the next word is taken; a second one waits in DONE.
// Reset: a clearing pass zeroes all STORE_BYTES (8192) bytes, one per cycle; req.ready is low.
`include "gray4_frame_buffer_engine_assert.svh"

module gray4_frame_buffer_engine
    import gfb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    gfb_req_if.sink   req,
    gfb_rsp_if.source rsp
);

    // Sequencer states
    localparam logic [2:0] ST_CLEAR   = 3'd0;  // zeroing sweep after reset
    localparam logic [2:0] ST_IDLE    = 3'd1;  // take a word, launch store read
    localparam logic [2:0] ST_EXEC    = 3'd2;  // read data back: write-back / result
    localparam logic [2:0] ST_DONE    = 3'd3;  // result parked, output register busy
    localparam logic [2:0] ST_FILL    = 3'd4;  // one fill byte: full write or read
    localparam logic [2:0] ST_FILL_WR = 3'd5;  // edge byte: merge and write back

    logic [2:0] state_reg, state_next;
    logic [ADDRW-1:0] clr_cnt_reg, clr_cnt_next;

    // Latched command context
    cmd_t             cmd_reg, cmd_next;
    logic             odd_reg, odd_next;
    logic [GRAYW-1:0] gray_reg, gray_next;
    logic             oor_reg, oor_next;
    logic [ADDRW-1:0] addr_reg, addr_next;

    // Fill walk: byte column cx over [cx_first, cx_last], row fy over [.., fy_hi)
    logic [XW-1:0]   fx_lo_reg, fx_lo_next;
    logic [XW-1:0]   fx_hi_reg, fx_hi_next;
    logic [YW-1:0]   fy_reg, fy_next;
    logic [YW-1:0]   fy_hi_reg, fy_hi_next;
    logic [COLW-1:0] cx_reg, cx_next;
    logic [COLW-1:0] cx_first_reg, cx_first_next;
    logic [COLW-1:0] cx_last_reg, cx_last_next;

    // Parked result and output register
    logic [GRAYW-1:0] res_pix_reg, res_pix_next;
    logic [BYTEW-1:0] res_byte_reg, res_byte_next;
    logic             res_oor_reg, res_oor_next;
    logic [GRAYW-1:0] out_pix_reg, out_pix_next;
    logic [BYTEW-1:0] out_byte_reg, out_byte_next;
    logic             out_oor_reg, out_oor_next;
    logic             out_valid_reg, out_valid_next;

    // Frame store, single read and single write port, registered read data
    logic [BYTEW-1:0] mem [STORE_BYTES];
    logic [BYTEW-1:0] rdata_reg;
    logic             rd_en;
    logic [ADDRW-1:0] rd_addr;
    logic             wr_en;
    logic [ADDRW-1:0] wr_addr;
    logic [BYTEW-1:0] wr_data;

    // Accept-side decode
    logic             accept;
    logic [XW-1:0]    xa, xb, xb_c;
    logic [YW-1:0]    ya, yb, yb_c;
    logic             fill_nonempty, fill_oor, fill_go;
    logic             pix_in, byte_in, acc_oor;
    logic [ADDRW-1:0] acc_addr;

    // Fill step decode
    logic             hi_cov, lo_cov;
    logic             col_last, row_last;
    logic [ADDRW-1:0] fill_addr;

    // Result of the word in EXEC
    logic [GRAYW-1:0] res_pix;
    logic [BYTEW-1:0] res_byte;
    logic             out_free;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.pixel_value  = out_pix_reg;
    assign rsp.read_byte    = out_byte_reg;
    assign rsp.out_of_range = out_oor_reg;

    // Corner ordering, emptiness and clipping of the fill rectangle; range flag and store address of the word
    always_comb
    begin
        xa = (req.x_end < req.x_start) ? req.x_end : req.x_start;
        xb = (req.x_end < req.x_start) ? req.x_start : req.x_end;
        ya = (req.y_end < req.y_start) ? req.y_end : req.y_start;
        yb = (req.y_end < req.y_start) ? req.y_start : req.y_end;
        xb_c = (xb > PANEL_WIDTH) ? XW'(PANEL_WIDTH) : xb;
        yb_c = (yb > PANEL_HEIGHT) ? YW'(PANEL_HEIGHT) : yb;
        fill_nonempty = (xa < xb) && (ya < yb);
        // flagged on the unclipped rectangle, even if nothing is left to write
        fill_oor = fill_nonempty && ((xb > PANEL_WIDTH) || (yb > PANEL_HEIGHT));
        fill_go  = fill_nonempty && (xa < xb_c) && (ya < yb_c);

        pix_in  = (req.x_start < PANEL_WIDTH) && (req.y_start < PANEL_HEIGHT);
        byte_in = (req.byte_index < STORE_BYTES);

        case (req.command)
            CMD_WRITE_PIXEL: acc_oor = !pix_in;
            CMD_FILL_RECT:   acc_oor = fill_oor;
            CMD_READ_PIXEL:  acc_oor = !pix_in;
            CMD_READ_BYTE:   acc_oor = !byte_in;
            default:         acc_oor = 1'b0;
        endcase

        if (req.command == CMD_READ_BYTE)
        begin
            acc_addr = ADDRW'(req.byte_index);
        end
        else
        begin
            acc_addr = pix_addr(req.y_start, COLW'(req.x_start >> 1));
        end
    end

    // Which nibbles of the current fill byte fall inside [fx_lo, fx_hi)
    always_comb
    begin
        hi_cov    = XW'({cx_reg, 1'b0}) >= fx_lo_reg;
        lo_cov    = XW'({cx_reg, 1'b1}) < fx_hi_reg;
        col_last  = (cx_reg == cx_last_reg);
        row_last  = (({1'b0, fy_reg} + 1'b1) == {1'b0, fy_hi_reg});
        fill_addr = pix_addr(fy_reg, cx_reg);
    end

    // Result from the store read; zero where the command does not return it or is out of range
    always_comb
    begin
        res_pix  = '0;
        res_byte = '0;
        if (cmd_reg == CMD_READ_PIXEL && !oor_reg)
        begin
            res_pix = odd_reg ? rdata_reg[GRAYW-1:0] : rdata_reg[BYTEW-1:GRAYW];
        end
        if (cmd_reg == CMD_READ_BYTE && !oor_reg)
        begin
            res_byte = rdata_reg;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cmd_next       = cmd_reg;
        odd_next       = odd_reg;
        gray_next      = gray_reg;
        oor_next       = oor_reg;
        addr_next      = addr_reg;
        fx_lo_next     = fx_lo_reg;
        fx_hi_next     = fx_hi_reg;
        fy_next        = fy_reg;
        fy_hi_next     = fy_hi_reg;
        cx_next        = cx_reg;
        cx_first_next  = cx_first_reg;
        cx_last_next   = cx_last_reg;
        res_pix_next   = res_pix_reg;
        res_byte_next  = res_byte_reg;
        res_oor_next   = res_oor_reg;
        out_pix_next   = out_pix_reg;
        out_byte_next  = out_byte_reg;
        out_oor_next   = out_oor_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        rd_en          = 1'b0;
        rd_addr        = acc_addr;
        wr_en          = 1'b0;
        wr_addr        = fill_addr;
        wr_data        = {gray_reg, gray_reg};

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDRW'(STORE_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    // store read launched straight from the request word
                    rd_en         = 1'b1;
                    rd_addr       = acc_addr;
                    cmd_next      = req.command;
                    odd_next      = req.x_start[0];
                    gray_next     = req.color[GRAYW-1:0];
                    oor_next      = acc_oor;
                    addr_next     = acc_addr;
                    fx_lo_next    = xa;
                    fx_hi_next    = xb_c;
                    fy_next       = ya;
                    fy_hi_next    = yb_c;
                    cx_next       = COLW'(xa >> 1);
                    cx_first_next = COLW'(xa >> 1);
                    cx_last_next  = COLW'((xb_c - 1'b1) >> 1);
                    if (req.command == CMD_FILL_RECT && fill_go)
                    begin
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end

            ST_EXEC:
            begin
                if (cmd_reg == CMD_WRITE_PIXEL && !oor_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = addr_reg;
                    wr_data = put_nibble(rdata_reg, !odd_reg, odd_reg, gray_reg);
                end
                if (out_free)
                begin
                    out_pix_next   = res_pix;
                    out_byte_next  = res_byte;
                    out_oor_next   = oor_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    res_pix_next  = res_pix;
                    res_byte_next = res_byte;
                    res_oor_next  = oor_reg;
                    state_next    = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_pix_next   = res_pix_reg;
                    out_byte_next  = res_byte_reg;
                    out_oor_next   = res_oor_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_FILL, ST_FILL_WR:
            begin
                if (state_reg == ST_FILL && !(hi_cov && lo_cov))
                begin
                    // edge byte: fetch it, merge next cycle
                    rd_en      = 1'b1;
                    rd_addr    = fill_addr;
                    state_next = ST_FILL_WR;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = fill_addr;
                    if (state_reg == ST_FILL_WR)
                    begin
                        wr_data = put_nibble(rdata_reg, hi_cov, lo_cov, gray_reg);
                    end
                    if (col_last)
                    begin
                        if (row_last)
                        begin
                            // EXEC reports the fill with oor_reg, no write-back
                            state_next = ST_EXEC;
                        end
                        else
                        begin
                            fy_next    = fy_reg + 1'b1;
                            cx_next    = cx_first_reg;
                            state_next = ST_FILL;
                        end
                    end
                    else
                    begin
                        cx_next    = cx_reg + 1'b1;
                        state_next = ST_FILL;
                    end
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Frame store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        odd_reg      <= odd_next;
        gray_reg     <= gray_next;
        oor_reg      <= oor_next;
        addr_reg     <= addr_next;
        fx_lo_reg    <= fx_lo_next;
        fx_hi_reg    <= fx_hi_next;
        fy_reg       <= fy_next;
        fy_hi_reg    <= fy_hi_next;
        cx_reg       <= cx_next;
        cx_first_reg <= cx_first_next;
        cx_last_reg  <= cx_last_next;
        res_pix_reg  <= res_pix_next;
        res_byte_reg <= res_byte_next;
        res_oor_reg  <= res_oor_next;
        out_pix_reg  <= out_pix_next;
        out_byte_reg <= out_byte_next;
        out_oor_reg  <= out_oor_next;
    end

    // Single-port discipline: no cycle both reads and writes the store
    `GFB_ASSERT_NEVER(a_rd_wr_excl, clk, rst_n, rd_en && wr_en)
    // Clearing sweep writes zero every cycle
    `GFB_ASSERT_IMPLY(a_clear_writes_zero, clk, rst_n, state_reg == ST_CLEAR, wr_en && wr_data == '0)
    // Fill walk never leaves the clipped rectangle
    `GFB_ASSERT_IMPLY(a_fill_bounds, clk, rst_n, state_reg == ST_FILL || state_reg == ST_FILL_WR, cx_reg <= cx_last_reg && fy_reg < fy_hi_reg)
    // Write-back in EXEC only for an in-panel pixel write
    `GFB_ASSERT_IMPLY(a_exec_write, clk, rst_n, state_reg == ST_EXEC && wr_en, cmd_reg == CMD_WRITE_PIXEL && !oor_reg)

endmodule

### tb/sv/gray4_frame_buffer_engine_test.sv
// Self-checking testbench for the gray frame store engine: directed table, then random traffic.
module gray4_frame_buffer_engine_test;
    import gfb_pkg::*;

    // One command word as offered on the request channel.
    typedef struct packed {
        cmd_t              command;
        logic [XW-1:0]     x_start;
        logic [YW-1:0]     y_start;
        logic [XW-1:0]     x_end;
        logic [YW-1:0]     y_end;
        logic [COLORW-1:0] color;
        logic [BIDXW-1:0]  byte_index;
    } gfb_word_t;

    // One result word as seen on the response channel.
    typedef struct packed {
        logic [GRAYW-1:0] pixel_value;
        logic [BYTEW-1:0] read_byte;
        logic             out_of_range;
    } gfb_result_t;

    // Directed row: the word, and a hand-typed result where one is obvious.
    typedef struct {
        gfb_word_t   word;
        bit          typed;
        gfb_result_t want;
    } dir_row_t;

    localparam int RANDOM_WORDS = 1050;
    // The limit leaves ample margin over the slowest correct run,
    // clearing pass and long receiver hold-offs included.
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 64;

    logic clk = 1'b0;
    logic rst_n;

    gfb_req_if req ();
    gfb_rsp_if rsp ();

    gray4_frame_buffer_engine dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Private copy of the frame store, updated in acceptance order.
    logic [BYTEW-1:0] frame_copy [STORE_BYTES];
    gfb_result_t      pending_results [$];
    dir_row_t         dir_rows [$];

    int errors       = 0;
    int results_seen = 0;
    int words_sent   = 0;
    int oor_words    = 0;
    int cmd_count [4];
    int burst_left   = 0;

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at result %0d: %s got 0x%0h expected 0x%0h",
                 results_seen, what, got, want);
        errors++;
    endtask

    function automatic void frame_put(input int x, input int y, input logic [GRAYW-1:0] gray);
        int addr;
        addr = (x >> 1) + y * ROW_BYTES;
        if (addr < STORE_BYTES)
        begin
            // even column lives in the high nibble
            if (x[0])
                frame_copy[addr][3:0] = gray;
            else
                frame_copy[addr][7:4] = gray;
        end
    endfunction

    function automatic logic [GRAYW-1:0] frame_get(input int x, input int y);
        int addr;
        addr = (x >> 1) + y * ROW_BYTES;
        if (addr >= STORE_BYTES)
            return '0;
        return x[0] ? frame_copy[addr][3:0] : frame_copy[addr][7:4];
    endfunction

    // Applies one word to the frame copy and returns the result it must cause.
    function automatic gfb_result_t frame_apply(input gfb_word_t w);
        gfb_result_t      r;
        int               xs, ys, xe, ye, t, x, y;
        logic [GRAYW-1:0] gray;
        r    = '0;
        xs   = int'(w.x_start);
        ys   = int'(w.y_start);
        xe   = int'(w.x_end);
        ye   = int'(w.y_end);
        gray = w.color[GRAYW-1:0];
        case (w.command)
            CMD_WRITE_PIXEL:
                if (xs < PANEL_WIDTH && ys < PANEL_HEIGHT)
                    frame_put(xs, ys, gray);
                else
                    r.out_of_range = 1'b1;
            CMD_FILL_RECT:
            begin
                // reversed corners are swapped, ends are exclusive
                if (xs > xe)
                begin
                    t = xs; xs = xe; xe = t;
                end
                if (ys > ye)
                begin
                    t = ys; ys = ye; ye = t;
                end
                // an empty range writes nothing and flags nothing
                if (xs < xe && ys < ye)
                begin
                    if (xe > PANEL_WIDTH)
                    begin
                        r.out_of_range = 1'b1;
                        xe = PANEL_WIDTH;
                    end
                    if (ye > PANEL_HEIGHT)
                    begin
                        r.out_of_range = 1'b1;
                        ye = PANEL_HEIGHT;
                    end
                    for (y = ys; y < ye; y++)
                        for (x = xs; x < xe; x++)
                            frame_put(x, y, gray);
                end
            end
            CMD_READ_PIXEL:
                if (xs < PANEL_WIDTH && ys < PANEL_HEIGHT)
                    r.pixel_value = frame_get(xs, ys);
                else
                    r.out_of_range = 1'b1;
            CMD_READ_BYTE:
                if (w.byte_index < STORE_BYTES)
                    r.read_byte = frame_copy[w.byte_index];
                else
                    r.out_of_range = 1'b1;
        endcase
        return r;
    endfunction

    function automatic gfb_word_t make_word(input cmd_t cmd, input int xs, input int ys,
                                            input int xe, input int ye, input int color,
                                            input int bidx);
        gfb_word_t w;
        w.command    = cmd;
        w.x_start    = XW'(xs);
        w.y_start    = YW'(ys);
        w.x_end      = XW'(xe);
        w.y_end      = YW'(ye);
        w.color      = COLORW'(color);
        w.byte_index = BIDXW'(bidx);
        return w;
    endfunction

    task automatic add_row(input cmd_t cmd, input int xs, input int ys, input int xe,
                           input int ye, input int color, input int bidx, input bit typed,
                           input int pv, input int rb, input int oor);
        dir_row_t row;
        row.word  = make_word(cmd, xs, ys, xe, ye, color, bidx);
        row.typed = typed;
        row.want  = '{pixel_value: GRAYW'(pv), read_byte: BYTEW'(rb), out_of_range: oor[0]};
        dir_rows.push_back(row);
    endtask

    // Sender idles: valid low, one assignment per falling edge.
    task automatic idle_for(input int n);
        repeat (n)
        begin
            @(negedge clk);
            req.valid <= 1'b0;
        end
    endtask

    // Offers one word and holds it until accepted, then books its result.
    task automatic send_word(input gfb_word_t w, input bit typed, input gfb_result_t want);
        gfb_result_t pr;
        @(negedge clk);
        req.valid      <= 1'b1;
        req.command    <= w.command;
        req.x_start    <= w.x_start;
        req.y_start    <= w.y_start;
        req.x_end      <= w.x_end;
        req.y_end      <= w.y_end;
        req.color      <= w.color;
        req.byte_index <= w.byte_index;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        // accepted at this edge; the frame copy moves in the same order
        pr = frame_apply(w);
        pending_results.push_back(typed ? want : pr);
        words_sent++;
        cmd_count[w.command]++;
        if (pr.out_of_range)
            oor_words++;
    endtask

    // Bursts of back-to-back words, random gaps between bursts.
    task automatic offer(input gfb_word_t w, input bit typed, input gfb_result_t want);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            idle_for(gap);
            burst_left = ($urandom_range(0, 15) == 0) ? $urandom_range(80, 200)
                                                      : $urandom_range(1, 24);
        end
        burst_left--;
        send_word(w, typed, want);
    endtask

    task automatic offer_checked(input gfb_word_t w);
        offer(w, 1'b0, '0);
    endtask

    task automatic build_directed();
        // fresh store reads back zero
        add_row(CMD_READ_BYTE,    0,   0,   0,   0, 0,    0,    1, 0, 0, 0);
        add_row(CMD_READ_BYTE,    0,   0,   0,   0, 0,    8191, 1, 0, 0, 0);
        add_row(CMD_READ_PIXEL,   255, 63,  0,   0, 0,    0,    1, 0, 0, 0);
        // pixel just past either edge, and far outside
        add_row(CMD_WRITE_PIXEL,  256, 0,   0,   0, 'h5a, 0,    1, 0, 0, 1);
        add_row(CMD_WRITE_PIXEL,  0,   64,  0,   0, 'ha5, 0,    1, 0, 0, 1);
        add_row(CMD_READ_PIXEL,   511, 127, 511, 127, 'hff, 8191, 1, 0, 0, 1);
        // both nibbles of byte 0, color masked to four bits
        add_row(CMD_WRITE_PIXEL,  0,   0,   0,   0, 'hff, 0,    1, 0, 0, 0);
        add_row(CMD_WRITE_PIXEL,  1,   0,   0,   0, 'h35, 0,    1, 0, 0, 0);
        add_row(CMD_READ_BYTE,    0,   0,   0,   0, 0,    0,    0, 0, 0, 0);
        add_row(CMD_READ_PIXEL,   0,   0,   0,   0, 0,    0,    0, 0, 0, 0);
        // reversed corners on both axes
        add_row(CMD_FILL_RECT,    10,  5,   4,   2, 'h07, 0,    1, 0, 0, 0);
        add_row(CMD_READ_PIXEL,   4,   2,   0,   0, 0,    0,    0, 0, 0, 0);
        add_row(CMD_READ_PIXEL,   10,  5,   0,   0, 0,    0,    0, 0, 0, 0);
        // empty column range, then empty row range
        add_row(CMD_FILL_RECT,    20,  0,   20,  10, 'h0b, 0,   1, 0, 0, 0);
        add_row(CMD_FILL_RECT,    0,   30,  50,  30, 'h0b, 0,   1, 0, 0, 0);
        // fill running past the panel corner, and one reversed past the bottom row
        add_row(CMD_FILL_RECT,    250, 60,  300, 100, 'h09, 0,  1, 0, 0, 1);
        add_row(CMD_FILL_RECT,    511, 127, 0,   63, 'h5a, 0,   1, 0, 0, 1);
        add_row(CMD_READ_BYTE,    0,   0,   0,   0, 0,    8191, 0, 0, 0, 0);
        // non-empty rectangle wholly right of the panel
        add_row(CMD_FILL_RECT,    256, 0,   300, 5, 'h0c, 0,    1, 0, 0, 1);
        // whole panel, ends exactly at the edges
        add_row(CMD_FILL_RECT,    0,   0,   256, 64, 'h03, 0,   1, 0, 0, 0);
        add_row(CMD_READ_BYTE,    0,   0,   0,   0, 0,    4096, 0, 0, 0, 0);
        add_row(CMD_WRITE_PIXEL,  255, 63,  0,   0, 'hfc, 0,    1, 0, 0, 0);
        add_row(CMD_READ_PIXEL,   255, 63,  0,   0, 0,    0,    0, 0, 0, 0);
        // odd start column: edge nibble read-modify-write
        add_row(CMD_FILL_RECT,    3,   1,   8,   2, 'h0e, 0,    1, 0, 0, 0);
        add_row(CMD_READ_BYTE,    0,   0,   0,   0, 0,    129,  0, 0, 0, 0);
    endtask

    // Random traffic: mostly well-formed write/readback and fill/probe groups.
    task automatic run_random();
        int count, pick, x0, y0, x1, y1, t, n, px, py, xlo, xhi, ylo, yhi;
        gfb_word_t w;
        count = 0;
        while (count < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                // write a pixel, read it back as nibble and maybe as byte
                x0 = $urandom_range(0, PANEL_WIDTH - 1);
                y0 = $urandom_range(0, PANEL_HEIGHT - 1);
                offer_checked(make_word(CMD_WRITE_PIXEL, x0, y0, $urandom, $urandom,
                                        $urandom, $urandom));
                offer_checked(make_word(CMD_READ_PIXEL, x0, y0, $urandom, $urandom,
                                        $urandom, $urandom));
                count += 2;
                if ($urandom_range(0, 1))
                begin
                    offer_checked(make_word(CMD_READ_BYTE, $urandom, $urandom, $urandom,
                                            $urandom, $urandom, (x0 >> 1) + y0 * ROW_BYTES));
                    count++;
                end
            end
            else if (pick < 55)
            begin
                // small fill, possibly empty, reversed or clipped, then probes
                x0 = $urandom_range(0, PANEL_WIDTH - 1);
                y0 = $urandom_range(0, PANEL_HEIGHT - 1);
                x1 = x0 + $urandom_range(0, 12);
                y1 = y0 + $urandom_range(0, 6);
                xlo = x0; xhi = x1; ylo = y0; yhi = y1;
                if ($urandom_range(0, 1))
                begin
                    t = x0; x0 = x1; x1 = t;
                end
                if ($urandom_range(0, 1))
                begin
                    t = y0; y0 = y1; y1 = t;
                end
                offer_checked(make_word(CMD_FILL_RECT, x0, y0, x1, y1, $urandom, $urandom));
                count++;
                n = $urandom_range(1, 3);
                repeat (n)
                begin
                    px = $urandom_range(xlo > 0 ? xlo - 1 : 0, xhi);
                    py = $urandom_range(ylo > 0 ? ylo - 1 : 0, yhi);
                    if ($urandom_range(0, 1))
                        w = make_word(CMD_READ_PIXEL, px, py, $urandom, $urandom,
                                      $urandom, $urandom);
                    else
                        w = make_word(CMD_READ_BYTE, $urandom, $urandom, $urandom,
                                      $urandom, $urandom,
                                      (px >> 1) + (py % PANEL_HEIGHT) * ROW_BYTES);
                    offer_checked(w);
                    count++;
                end
            end
            else if (pick < 75)
            begin
                // reads anywhere in the store
                if ($urandom_range(0, 1))
                    w = make_word(CMD_READ_PIXEL, $urandom_range(0, PANEL_WIDTH - 1),
                                  $urandom_range(0, PANEL_HEIGHT - 1), $urandom, $urandom,
                                  $urandom, $urandom);
                else
                    w = make_word(CMD_READ_BYTE, $urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom);
                offer_checked(w);
                count++;
            end
            else if (pick < 85)
            begin
                // pixel access outside the panel on one or both axes
                if ($urandom_range(0, 1))
                begin
                    px = $urandom_range(PANEL_WIDTH, 511);
                    py = $urandom_range(0, 127);
                end
                else
                begin
                    px = $urandom_range(0, 511);
                    py = $urandom_range(PANEL_HEIGHT, 127);
                end
                offer_checked(make_word($urandom_range(0, 1) ? CMD_WRITE_PIXEL : CMD_READ_PIXEL,
                                        px, py, $urandom, $urandom, $urandom, $urandom));
                count++;
            end
            else
            begin
                // raw noise on every field; most noise fills kept a few rows tall
                w = make_word(cmd_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom);
                if (w.command == CMD_FILL_RECT && $urandom_range(0, 3) != 0)
                    w.y_end = w.y_start + YW'($urandom_range(0, 2));
                offer_checked(w);
                count++;
            end
        end
    endtask

    // Stimulus: reset, directed table, random traffic, drain, verdict.
    initial
    begin
        req.valid      = 1'b0;
        req.command    = CMD_WRITE_PIXEL;
        req.x_start    = '0;
        req.y_start    = '0;
        req.x_end      = '0;
        req.y_end      = '0;
        req.color      = '0;
        req.byte_index = '0;
        rst_n          = 1'b0;
        foreach (frame_copy[i])
            frame_copy[i] = '0;
        foreach (cmd_count[i])
            cmd_count[i] = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // the clearing pass keeps req.ready low; send_word simply waits it out
        build_directed();
        foreach (dir_rows[i])
            offer(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);

        run_random();
        idle_for(1);

        while (pending_results.size() != 0)
            @(posedge clk);
        // no stray words may follow the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d words: %0d pixel writes, %0d fills, %0d pixel reads,",
                 words_sent, cmd_count[CMD_WRITE_PIXEL], cmd_count[CMD_FILL_RECT],
                 cmd_count[CMD_READ_PIXEL]);
        $display("%0d byte reads; %0d results checked, %0d flagged out of range, %0d mismatches",
                 cmd_count[CMD_READ_BYTE], results_seen, oor_words, errors);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Receiver: changing stall patterns, plus long hold-offs that back the
    // block up until it stalls its request side.
    initial
    begin
        int mode, mode_left, hold_left, phase;
        bit first_hold, second_hold;
        rsp.ready   = 1'b0;
        mode        = 0;
        mode_left   = 0;
        hold_left   = 0;
        phase       = 0;
        first_hold  = 1'b0;
        second_hold = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!first_hold && results_seen >= 60)
            begin
                first_hold = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (!second_hold && results_seen >= 700)
            begin
                second_hold = 1'b1;
                hold_left   = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: rsp.ready <= 1'b1;
                    1: rsp.ready <= 1'($urandom_range(0, 1));
                    2: rsp.ready <= (phase % 4 == 0);
                    default: rsp.ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Checker: each accepted result against the oldest expectation.
    initial
    begin
        gfb_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp.valid && rsp.ready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                    flag_mismatch("result with nothing pending", 1, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp.pixel_value !== want.pixel_value)
                        flag_mismatch("pixel_value", int'(rsp.pixel_value),
                                      int'(want.pixel_value));
                    if (rsp.read_byte !== want.read_byte)
                        flag_mismatch("read_byte", int'(rsp.read_byte),
                                      int'(want.read_byte));
                    if (rsp.out_of_range !== want.out_of_range)
                        flag_mismatch("out_of_range", int'(rsp.out_of_range),
                                      int'(want.out_of_range));
                end
            end
        end
    end

    // Watchdog.
    initial
    begin
        #(LIMIT_CYCLES * 8);
        $display("Timeout with %0d results still pending", pending_results.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
